// ===== hw/rtl/nsc_pkg.sv =====
`default_nettype none

package nsc_pkg;

	// Field widths fixed by the item and result formats.
	localparam int PIXEL_BITS      = 32;
	localparam int ROW_BITS        = 16;
	localparam int FRAME_COLS_BITS = 11;
	localparam int COUNT_BITS      = 4;
	localparam int CFG_INDEX_BITS  = 2;
	localparam int CFG_DATA_BITS   = 16;
	localparam int WIN_TAPS        = 9;

	// Result queue; the depth must stay a power of two so the pointers wrap.
	localparam int FIFO_DEPTH    = 8;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_ROWS = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_COLS = 2'd1;

	typedef logic signed [PIXEL_BITS-1:0] pixel_t;

	typedef struct packed {
		logic   kind;
		pixel_t pixel_value;
	} item_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] smaller_count;
		logic                  end_of_row;
		logic                  end_of_frame;
	} result_t;

	// Window taps, index row * 3 + column; row 1 holds the center row.
	typedef pixel_t [WIN_TAPS-1:0] window_t;

	// Line store read data: port A and port B, upper and middle rows.
	typedef struct packed {
		pixel_t a_upper;
		pixel_t a_middle;
		pixel_t b_upper;
		pixel_t b_middle;
	} line_cols_t;

	// Per-item control decided when the item is accepted.
	typedef struct packed {
		logic is_pixel;
		logic emit_a;
		logic emit_b;
		logic up;
		logic down;
		logic left_a;
		logic right_a;
		logic left_b;
		logic eor_a;
		logic eof_a;
	} ctrl_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

	// Counts neighbors smaller than the center tap. The center sits in row 1,
	// column 1 or, when ctr_is_right is set, column 2.
	function automatic logic [COUNT_BITS-1:0] count_smaller(
		input window_t w,
		input logic    ctr_is_right,
		input logic    up,
		input logic    down,
		input logic    left,
		input logic    right
	);
		logic [COUNT_BITS-1:0] cnt;
		pixel_t                ctr;
		int                    cc;
		int                    row;
		int                    col;
		logic                  use_it;
		cc  = ctr_is_right ? 2 : 1;
		ctr = w[3 + cc];
		cnt = '0;
		for (row = 0; row < 3; row++) begin
			for (col = 0; col < 3; col++) begin
				use_it = 1'b1;
				if (row == 1 && col == cc) use_it = 1'b0;
				if (row == 0 && !up) use_it = 1'b0;
				if (row == 2 && !down) use_it = 1'b0;
				if (col < cc - 1) use_it = 1'b0;
				if (col < cc && !left) use_it = 1'b0;
				if (col > cc && !right) use_it = 1'b0;
				if (use_it && ($signed(ctr) > $signed(w[row * 3 + col]))) begin
					cnt = cnt + COUNT_BITS'(1);
				end
			end
		end
		return cnt;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nsc_line_stores.sv =====
`default_nettype none

// Upper and middle line stores with two registered read ports and one
// write port. A write in the same cycle as a read of the same column is
// forwarded to the read data.
module nsc_line_stores #(
	parameter int  MAX_COLS = 1024,
	localparam int AW       = $clog2(MAX_COLS)
) (
	input  wire logic                 clk,
	input  wire logic [AW-1:0]        rd_addr_a,
	input  wire logic [AW-1:0]        rd_addr_b,
	input  wire logic                 wr_en,
	input  wire logic [AW-1:0]        wr_addr,
	input  wire nsc_pkg::pixel_t      wr_upper,
	input  wire nsc_pkg::pixel_t      wr_middle,
	output nsc_pkg::line_cols_t       cols
);

	nsc_pkg::pixel_t upper_mem [MAX_COLS];
	nsc_pkg::pixel_t middle_mem [MAX_COLS];

	nsc_pkg::pixel_t a_up_q, a_mid_q, b_up_q, b_mid_q;
	nsc_pkg::pixel_t fwd_up_q, fwd_mid_q;
	logic            hit_a_q, hit_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			upper_mem[wr_addr] <= wr_upper;
		end
		a_up_q <= upper_mem[rd_addr_a];
		b_up_q <= upper_mem[rd_addr_b];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			middle_mem[wr_addr] <= wr_middle;
		end
		a_mid_q <= middle_mem[rd_addr_a];
		b_mid_q <= middle_mem[rd_addr_b];
	end

	always_ff @(posedge clk) begin
		hit_a_q   <= wr_en && (wr_addr == rd_addr_a);
		hit_b_q   <= wr_en && (wr_addr == rd_addr_b);
		fwd_up_q  <= wr_upper;
		fwd_mid_q <= wr_middle;
	end

	assign cols.a_upper  = hit_a_q ? fwd_up_q : a_up_q;
	assign cols.a_middle = hit_a_q ? fwd_mid_q : a_mid_q;
	assign cols.b_upper  = hit_b_q ? fwd_up_q : b_up_q;
	assign cols.b_middle = hit_b_q ? fwd_mid_q : b_mid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/nsc_result_fifo.sv =====
`default_nettype none

// Result queue: up to two results written per cycle, one read per cycle.
module nsc_result_fifo (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire nsc_pkg::push_t                    push,
	input  wire logic                              pop,
	output nsc_pkg::result_t                       head,
	output logic [nsc_pkg::FIFO_CNT_BITS-1:0]      count
);

	localparam int PW = nsc_pkg::FIFO_PTR_BITS;
	localparam int CNW = nsc_pkg::FIFO_CNT_BITS;

	nsc_pkg::result_t mem_q [nsc_pkg::FIFO_DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNW-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[PW'(wr_ptr_q + PW'(1))] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= PW'(wr_ptr_q + PW'(push.count));
			rd_ptr_q <= PW'(rd_ptr_q + PW'(pop));
			count_q  <= CNW'(count_q + CNW'(push.count) - CNW'(pop));
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign count = count_q;

endmodule

`default_nettype wire

// ===== hw/rtl/neighbor_smaller_count_3x3_top.sv =====
`default_nettype none

// Streaming 3x3 smaller-neighbor counter. Pixels of a frame of frame_rows by
// frame_cols signed values arrive in raster order, one transfer per clock
// unless item_stall is raised, and for each pixel the block reports how many
// of its in-frame neighbors are strictly smaller. Results of row r-1 leave
// while row r streams in; after the last pixel of a frame, drain items flush
// the last row, one result each, and drain items that find nothing pending
// are absorbed without a result. The block takes one item per clock while
// item_stall is low: the line stores are read once per item and written back
// in the cycle after, with the write forwarded to a read of the same column.
// A result passes the stage 1 and stage 2 registers and then waits in an
// eight-entry queue, so an input transfer proceeds while earlier results are
// stalled; the input stalls only when the queue could not hold the results
// still in flight. From the second row on, the pixel that closes a row of two
// or more columns yields two results. No clearing pass runs after reset: line
// store entries not yet written in the current frame never reach a count.
module neighbor_smaller_count_3x3_top #(
	parameter int MAX_COLS = 1024
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 item_valid,
	output logic                                      item_stall,
	input  wire nsc_pkg::item_t                       item,
	output logic                                      result_valid,
	input  wire logic                                 result_stall,
	output nsc_pkg::result_t                          result,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [nsc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [nsc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	// Column address width, and a width that holds the column count itself.
	localparam int AW   = $clog2(MAX_COLS);
	localparam int CW   = $clog2(MAX_COLS + 1);
	localparam int CMPW = (CW > nsc_pkg::FRAME_COLS_BITS) ? CW : nsc_pkg::FRAME_COLS_BITS;
	localparam int RB   = nsc_pkg::ROW_BITS;
	localparam int RSW  = nsc_pkg::FIFO_CNT_BITS + 1;

	// Configuration registers.
	logic [RB-1:0]                        frame_rows_q;
	logic [nsc_pkg::FRAME_COLS_BITS-1:0]  frame_cols_q;

	// Position counters: where the next pixel lands and which result is next.
	logic [RB-1:0] in_row_q, out_row_q;
	logic [AW-1:0] in_col_q, out_col_q;

	// Front-end decode of the item offered on the input.
	logic [RB-1:0]   m;
	logic [CMPW-1:0] fc, nc;
	logic [CW-1:0]   n;
	logic            restart;
	logic [RB-1:0]   r;
	logic [AW-1:0]   c;
	logic [CW-1:0]   c_ext, oc_ext;
	logic            row_end, can_drain, drain_eor, last_row;
	logic            keep;
	nsc_pkg::ctrl_t  ctrl_d;
	logic [AW-1:0]   rd_addr_a, rd_addr_b;
	logic [RB-1:0]   in_row_d, out_row_d;
	logic [AW-1:0]   in_col_d, out_col_d;
	logic            accept;
	logic            cfg_write;

	// Pipeline: stage 1 holds the line store read data, stage 2 the window.
	logic                valid_s1, valid_s2;
	nsc_pkg::ctrl_t      ctrl_s1, ctrl_s2;
	nsc_pkg::pixel_t     pix_s1;
	logic [AW-1:0]       addr_s1;
	nsc_pkg::line_cols_t cols;
	nsc_pkg::window_t    window_q;

	logic [nsc_pkg::COUNT_BITS-1:0]    cnt_a, cnt_b;
	nsc_pkg::result_t                  res_a, res_b;
	nsc_pkg::push_t                    push;
	logic [nsc_pkg::FIFO_CNT_BITS-1:0] fifo_count;
	logic [1:0]                        pend_s1, pend_s2;
	logic [RSW-1:0]                    reserved;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign accept    = item_valid && !item_stall;

	// Frame size as the datapath sees it: zero rows or columns act as one, and
	// the column count is clamped to the line store depth.
	always_comb begin
		m  = (frame_rows_q == '0) ? RB'(1) : frame_rows_q;
		fc = CMPW'(frame_cols_q);
		if (fc == '0) begin
			nc = CMPW'(1);
		end else if (fc > CMPW'(MAX_COLS)) begin
			nc = CMPW'(MAX_COLS);
		end else begin
			nc = fc;
		end
		n = CW'(nc);
	end

	// Decide everything about an item at the moment of its transfer: which
	// results it yields, their edge masks and flags, the line store columns to
	// read and the next counter values. A pixel that arrives after a complete
	// frame starts a new frame and drops results that were not drained.
	always_comb begin
		restart   = (in_row_q >= m) || (CW'(in_col_q) >= n);
		r         = restart ? '0 : in_row_q;
		c         = restart ? '0 : in_col_q;
		c_ext     = CW'(c);
		oc_ext    = CW'(out_col_q);
		row_end   = (c_ext + CW'(1)) >= n;
		can_drain = (in_row_q >= m) && (out_row_q < m) && (oc_ext < n);
		drain_eor = (oc_ext + CW'(1)) == n;
		last_row  = ({1'b0, out_row_q} + (RB + 1)'(1)) == {1'b0, m};

		ctrl_d    = '0;
		keep      = 1'b0;
		rd_addr_a = c;
		rd_addr_b = c;
		in_row_d  = in_row_q;
		in_col_d  = in_col_q;
		out_row_d = out_row_q;
		out_col_d = out_col_q;

		if (item.kind == nsc_pkg::KIND_PIXEL) begin
			keep            = 1'b1;
			ctrl_d.is_pixel = 1'b1;
			// Result for the column before this one, centered in window column 1.
			ctrl_d.emit_a   = (r != '0) && (c_ext >= CW'(1));
			// At the row's last column, its own result too, centered in column 2.
			ctrl_d.emit_b   = (r != '0) && ((c_ext + CW'(1)) == n);
			ctrl_d.up       = r >= RB'(2);
			ctrl_d.down     = 1'b1;
			ctrl_d.left_a   = c_ext >= CW'(2);
			ctrl_d.right_a  = 1'b1;
			ctrl_d.left_b   = c_ext >= CW'(1);
			// A pixel's results belong to an earlier row, so they never close
			// the frame, and only the result for the row's last column closes its row.
			ctrl_d.eor_a    = 1'b0;
			ctrl_d.eof_a    = 1'b0;

			in_col_d = row_end ? '0 : AW'(c_ext + CW'(1));
			in_row_d = row_end ? RB'(r + RB'(1)) : r;
			if (restart) begin
				out_row_d = '0;
				out_col_d = '0;
			end
			if (ctrl_d.emit_b) begin
				out_col_d = '0;
				out_row_d = r;
			end else if (ctrl_d.emit_a) begin
				out_col_d = c;
				out_row_d = RB'(r - RB'(1));
			end
		end else begin
			// Drain: port A reads the center column, port B the one to its
			// right; the left column is still in the window from the last drain.
			keep            = can_drain;
			ctrl_d.emit_a   = can_drain;
			ctrl_d.up       = out_row_q != '0;
			ctrl_d.down     = !last_row;
			ctrl_d.left_a   = oc_ext >= CW'(1);
			ctrl_d.right_a  = (oc_ext + CW'(1)) < n;
			ctrl_d.eor_a    = drain_eor;
			ctrl_d.eof_a    = drain_eor && last_row;
			rd_addr_a       = out_col_q;
			rd_addr_b       = AW'(oc_ext + CW'(1));
			if (can_drain) begin
				if (drain_eor) begin
					out_col_d = '0;
					out_row_d = RB'(out_row_q + RB'(1));
				end else begin
					out_col_d = AW'(oc_ext + CW'(1));
				end
			end
		end
	end

	// Configuration and position counters. A write to either geometry register restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q <= RB'(1);
			frame_cols_q <= nsc_pkg::FRAME_COLS_BITS'(1);
			in_row_q     <= '0;
			in_col_q     <= '0;
			out_row_q    <= '0;
			out_col_q    <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				nsc_pkg::REG_FRAME_ROWS: begin
					frame_rows_q <= cfg_data[RB-1:0];
					in_row_q     <= '0;
					in_col_q     <= '0;
					out_row_q    <= '0;
					out_col_q    <= '0;
				end
				nsc_pkg::REG_FRAME_COLS: begin
					frame_cols_q <= cfg_data[nsc_pkg::FRAME_COLS_BITS-1:0];
					in_row_q     <= '0;
					in_col_q     <= '0;
					out_row_q    <= '0;
					out_col_q    <= '0;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			in_row_q  <= in_row_d;
			in_col_q  <= in_col_d;
			out_row_q <= out_row_d;
			out_col_q <= out_col_d;
		end
	end

	// Drains that yield nothing stop here and never enter the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept && keep;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		ctrl_s1 <= ctrl_d;
		pix_s1  <= item.pixel_value;
		addr_s1 <= rd_addr_a;
		ctrl_s2 <= ctrl_s1;
	end

	// Line stores: read at transfer, written back from stage 1. A pixel moves
	// the middle row entry up and puts itself into the middle row.
	nsc_line_stores #(
		.MAX_COLS (MAX_COLS)
	) u_line_stores (
		.clk       (clk),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.wr_en     (valid_s1 && ctrl_s1.is_pixel),
		.wr_addr   (addr_s1),
		.wr_upper  (cols.a_middle),
		.wr_middle (pix_s1),
		.cols      (cols)
	);

	// Window: a pixel shifts in its column of three rows. A drain loads the
	// center and right columns of the upper and middle rows; the bottom row is
	// never used then because a drain only serves the last row of the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (valid_s1) begin
			if (ctrl_s1.is_pixel) begin
				for (int row = 0; row < 3; row++) begin
					window_q[row * 3 + 0] <= window_q[row * 3 + 1];
					window_q[row * 3 + 1] <= window_q[row * 3 + 2];
				end
				window_q[2] <= cols.a_upper;
				window_q[5] <= cols.a_middle;
				window_q[8] <= pix_s1;
			end else begin
				window_q[0] <= window_q[1];
				window_q[1] <= cols.a_upper;
				window_q[2] <= cols.b_upper;
				window_q[3] <= window_q[4];
				window_q[4] <= cols.a_middle;
				window_q[5] <= cols.b_middle;
			end
		end
	end

	// Stage 2: count against the window and hand the results to the queue.
	always_comb begin
		cnt_a = nsc_pkg::count_smaller(window_q, 1'b0, ctrl_s2.up, ctrl_s2.down,
			ctrl_s2.left_a, ctrl_s2.right_a);
		cnt_b = nsc_pkg::count_smaller(window_q, 1'b1, ctrl_s2.up, ctrl_s2.down,
			ctrl_s2.left_b, 1'b0);
		res_a.smaller_count = cnt_a;
		res_a.end_of_row    = ctrl_s2.eor_a;
		res_a.end_of_frame  = ctrl_s2.eof_a;
		res_b.smaller_count = cnt_b;
		res_b.end_of_row    = 1'b1;
		res_b.end_of_frame  = 1'b0;

		push.count  = 2'd0;
		push.first  = res_a;
		push.second = res_b;
		if (valid_s2) begin
			if (ctrl_s2.emit_a && ctrl_s2.emit_b) begin
				push.count = 2'd2;
			end else if (ctrl_s2.emit_a) begin
				push.count = 2'd1;
			end else if (ctrl_s2.emit_b) begin
				push.count = 2'd1;
				push.first = res_b;
			end
		end
	end

	nsc_result_fifo u_result_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (result_valid && !result_stall),
		.head   (result),
		.count  (fifo_count)
	);

	assign result_valid = fifo_count != '0;

	// Input flow control: the queue must have room for every result still in
	// the pipeline plus the two that the next item may add.
	assign pend_s1  = valid_s1 ? (2'(ctrl_s1.emit_a) + 2'(ctrl_s1.emit_b)) : 2'd0;
	assign pend_s2  = valid_s2 ? (2'(ctrl_s2.emit_a) + 2'(ctrl_s2.emit_b)) : 2'd0;
	assign reserved = RSW'(fifo_count) + RSW'(pend_s1) + RSW'(pend_s2);
	assign item_stall = reserved > RSW'(nsc_pkg::FIFO_DEPTH - 2);

endmodule

`default_nettype wire

// ===== hw/rtl/nsc_checker.sv =====
`default_nettype none

module nsc_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 item_valid,
	input wire logic                                 item_stall,
	input wire nsc_pkg::item_t                       item,
	input wire logic                                 result_valid,
	input wire logic                                 result_stall,
	input wire nsc_pkg::result_t                     result,
	input wire logic                                 cfg_valid,
	input wire logic                                 cfg_ready,
	input wire logic [nsc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input wire logic [nsc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	// A stalled result stays offered and unchanged.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed or was withdrawn");

	// A pixel has at most eight neighbors, and the last pixel of a frame is
	// also the last of its row.
	a_result_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.smaller_count <= 4'd8) &&
			(!result.end_of_frame || result.end_of_row))
		else $error("result fields out of range");

	// No result is offered right after reset.
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !result_valid)
		else $error("result offered right after reset");

	// A stalled input item stays offered and unchanged.
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("stalled item changed or was withdrawn");

	// Register writes arrive only while both data channels are idle.
	a_cfg_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !item_valid && !result_valid &&
			!$isunknown({cfg_index, cfg_data}))
		else $error("register write while items are in flight");

endmodule

bind neighbor_smaller_count_3x3_top nsc_checker u_nsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready),
	.cfg_index    (cfg_index),
	.cfg_data     (cfg_data)
);

`default_nettype wire

// ===== sim/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import nsc_pkg::*;

	// Line depth of the instance under test; frame_cols settings above it are clamped.
	localparam int LINE_DEPTH     = 1024;
	// Rough number of random items (pixels plus drain ticks that flush a result).
	localparam int RANDOM_ITEMS   = 120;
	// A result passes stage 1, stage 2 and the result queue after its transfer, so
	// SETTLE_CYCLES of quiet are enough for anything still in the pipeline to surface.
	localparam int SETTLE_CYCLES  = 8;
	// Clocks without any transfer on any channel before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 4000;

	// Register indexes past the end of the register list; writes to them are ignored.
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;

	localparam pixel_t PIX_MIN = {1'b1, {(PIXEL_BITS - 1){1'b0}}};
	localparam pixel_t PIX_MAX = {1'b0, {(PIXEL_BITS - 1){1'b1}}};

	// How pixel values are drawn: the full range, a narrow band full of ties, or
	// only the corner values of the signed range.
	typedef enum int {VAL_FULL, VAL_TIES, VAL_EXTREME} value_mix_t;

	// Behavior of the result side while it is in a given stall mode.
	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mix_t;

	// Every input of the block has a known value from time zero.
	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      item_valid   = 1'b0;
	logic                      item_stall;
	item_t                     in_item      = '0;
	logic                      result_valid;
	logic                      result_stall = 1'b0;
	result_t                   out_result;
	logic                      cfg_valid    = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;

	neighbor_smaller_count_3x3_top #(
		.MAX_COLS(LINE_DEPTH)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (in_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (out_result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// Shadow copy of the block's state. The line stores and the window hold raw
	// signed pixels; only the positions that fall inside the frame ever reach a
	// count, so the values of entries never written do not matter.
	pixel_t                     upper_line  [LINE_DEPTH];
	pixel_t                     middle_line [LINE_DEPTH];
	window_t                    win         = '0;
	logic [ROW_BITS-1:0]        rows_reg    = 16'd1;
	logic [FRAME_COLS_BITS-1:0] cols_reg    = 11'd1;
	int                         in_row      = 0;
	int                         in_col      = 0;
	int                         out_row     = 0;
	int                         out_col     = 0;

	// Results predicted but not yet seen, oldest first, and items waiting to go out.
	result_t expected_counts [$];
	item_t   pending_items   [$];

	// Sender burst shaping, receiver stall shaping and bookkeeping.
	bit         item_taken      = 1'b0;
	int         burst_left      = 0;
	int         gap_left        = 0;
	stall_mix_t stall_mix       = STALL_NONE;
	int         stall_left      = 0;
	int         stall_tick      = 0;
	int         quiet_cycles    = 0;
	int         mismatches      = 0;
	int         results_checked = 0;
	int         pixels_queued   = 0;
	int         drains_queued   = 0;
	int         geometries      = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	// Effective geometry: zero rows or columns act as one, and the column count
	// never exceeds what the line stores can hold.
	function automatic int rows_in_use();
		return (rows_reg == '0) ? 1 : int'(rows_reg);
	endfunction

	function automatic int cols_in_use();
		int n;
		n = (cols_reg == '0) ? 1 : int'(cols_reg);
		return (n > LINE_DEPTH) ? LINE_DEPTH : n;
	endfunction

	function automatic void restart_frame();
		in_row  = 0;
		in_col  = 0;
		out_row = 0;
		out_col = 0;
	endfunction

	// A write to either geometry register restarts the frame; spare indexes are
	// ignored and leave the position counters alone.
	function automatic void apply_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		case (idx)
			REG_FRAME_ROWS: begin
				rows_reg = data;
				restart_frame();
			end
			REG_FRAME_COLS: begin
				cols_reg = data[FRAME_COLS_BITS-1:0];
				restart_frame();
			end
			default: ;
		endcase
	endfunction

	// Counts the neighbors of the center tap (row 1, column cc) that are strictly
	// smaller, skipping the sides the flags mark as outside the frame.
	function automatic logic [COUNT_BITS-1:0] neighbors_below(input window_t w, input int cc,
			input logic up, input logic down, input logic left, input logic right);
		logic [COUNT_BITS-1:0] n_below;
		int                    dr;
		int                    dc;
		int                    col;
		n_below = '0;
		for (dr = -1; dr <= 1; dr++) begin
			for (dc = -1; dc <= 1; dc++) begin
				col = cc + dc;
				if (!(dr == 0 && dc == 0) && !(dr < 0 && !up) && !(dr > 0 && !down) &&
						!(dc < 0 && !left) && !(dc > 0 && !right) && col >= 0 && col <= 2) begin
					if ($signed(w[3 + cc]) > $signed(w[(dr + 1) * 3 + col])) n_below++;
				end
			end
		end
		return n_below;
	endfunction

	// Queues the result for position (orow, ocol) and moves the output position on.
	function automatic void expect_result(input logic [COUNT_BITS-1:0] cnt, input int orow,
			input int ocol);
		result_t r;
		r.smaller_count = cnt;
		r.end_of_row    = (ocol + 1 == cols_in_use());
		r.end_of_frame  = r.end_of_row && (orow + 1 == rows_in_use());
		expected_counts.push_back(r);
		if (r.end_of_row) begin
			out_col = 0;
			out_row = orow + 1;
		end else begin
			out_col = ocol + 1;
			out_row = orow;
		end
	endfunction

	// Works out the results that one accepted item causes.
	function automatic void predict_counts(input item_t it);
		int      m;
		int      n;
		int      r;
		int      c;
		int      d;
		int      col;
		pixel_t  above;
		pixel_t  mid;
		window_t w;
		m = rows_in_use();
		n = cols_in_use();
		if (it.kind == KIND_PIXEL) begin
			// A pixel after a complete frame opens the next one; whatever of the
			// last row was not drained is lost.
			if (in_row >= m || in_col >= n) restart_frame();
			r = in_row;
			c = in_col % LINE_DEPTH;
			above = upper_line[c];
			mid   = middle_line[c];
			upper_line[c]  = mid;
			middle_line[c] = it.pixel_value;
			for (d = 0; d < 3; d++) begin
				win[d * 3]     = win[d * 3 + 1];
				win[d * 3 + 1] = win[d * 3 + 2];
			end
			win[2] = above;
			win[5] = mid;
			win[8] = it.pixel_value;
			// Row r completes the neighborhood of row r-1: the pixel one column
			// back, and at the row's end the last column as well.
			if (r >= 1) begin
				if (c >= 1) begin
					expect_result(neighbors_below(win, 1, r >= 2, 1'b1, c >= 2, 1'b1), r - 1, c - 1);
				end
				if (c + 1 == n) begin
					expect_result(neighbors_below(win, 2, r >= 2, 1'b1, c >= 1, 1'b0), r - 1, c);
				end
			end
			if (c + 1 >= n) begin
				in_col = 0;
				in_row = r + 1;
			end else begin
				in_col = c + 1;
			end
		end else if (in_row >= m && out_row < m && out_col < n) begin
			// A drain tick flushes one result of the last row from the line stores.
			w = '0;
			for (d = -1; d <= 1; d++) begin
				col = out_col + d;
				if (col >= 0 && col < n) begin
					w[d + 1] = upper_line[col];
					w[d + 4] = middle_line[col];
				end
			end
			expect_result(neighbors_below(w, 1, out_row >= 1, out_row + 1 < m, out_col >= 1,
				out_col + 1 < n), out_row, out_col);
		end
	endfunction

	function automatic pixel_t pick_pixel(input value_mix_t mix);
		case (mix)
			VAL_TIES: return pixel_t'($urandom_range(0, 4)) - 2;
			VAL_EXTREME: begin
				case ($urandom_range(0, 4))
					0:       return PIX_MIN;
					1:       return PIX_MAX;
					2:       return '0;
					3:       return -1;
					default: return 1;
				endcase
			end
			default: return pixel_t'($urandom);
		endcase
	endfunction

	function automatic void queue_pixel_value(input pixel_t v);
		pending_items.push_back('{kind: KIND_PIXEL, pixel_value: v});
		pixels_queued++;
	endfunction

	function automatic void queue_pixel(input value_mix_t mix);
		queue_pixel_value(pick_pixel(mix));
	endfunction

	// Drain ticks carry a random payload, which the block must ignore.
	function automatic void queue_drains(input int count);
		int k;
		for (k = 0; k < count; k++) begin
			pending_items.push_back('{kind: KIND_DRAIN, pixel_value: pixel_t'($urandom)});
			drains_queued++;
		end
	endfunction

	// Waits until every queued item has been transferred and every predicted result
	// has arrived, then waits out SETTLE_CYCLES more for items that produce no result.
	task automatic wait_for_quiet();
		while (pending_items.size() != 0 || item_valid || expected_counts.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write on the configuration channel; the shadow copy is updated
	// at the edge where the transfer happens.
	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Sender: works through the pending queue in bursts of random length separated by
	// random gaps. About half the gaps are empty, which gives long back-to-back
	// stretches. A payload stays put until its transfer completes.
	always @(negedge clk) begin : drive_items
		logic  next_valid;
		item_t next_item;
		next_valid = item_valid;
		next_item  = in_item;
		if (!arst_n) begin
			next_valid = 1'b0;
		end else if (!item_valid || item_taken) begin
			next_valid = 1'b0;
			if (gap_left != 0) begin
				gap_left--;
			end else if (pending_items.size() != 0) begin
				next_item  = pending_items.pop_front();
				next_valid = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 48);
					gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
				end
			end
		end
		item_valid <= next_valid;
		in_item    <= next_item;
	end

	// Receiver: switches between stall modes every so often, from never stalling
	// to stalling most of the time, so that full result queues and input back
	// pressure both happen.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mix  = stall_mix_t'($urandom_range(0, 3));
			stall_left = $urandom_range(16, 160);
		end
		stall_left--;
		stall_tick++;
		case (stall_mix)
			STALL_NONE:  result_stall <= 1'b0;
			STALL_LIGHT: result_stall <= ($urandom_range(0, 7) == 0);
			STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
			default:     result_stall <= (stall_tick % 5 < 2);
		endcase
	end

	// Monitor: at each rising edge, check a result transfer against the oldest
	// prediction, then feed an input transfer to the predictor. A result seen at
	// this edge cannot stem from the item taken at this same edge, so the order
	// of the two steps does not matter.
	always @(posedge clk) begin : check_and_predict
		result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_counts.size() == 0) begin
					$display("%0t: result with nothing expected: count %0d, end_of_row %0b, end_of_frame %0b",
						$time, out_result.smaller_count, out_result.end_of_row,
						out_result.end_of_frame);
					mismatches++;
				end else begin
					want = expected_counts.pop_front();
					results_checked++;
					if (out_result.smaller_count !== want.smaller_count) begin
						$display("%0t: smaller_count expected %0d, actual %0d", $time,
							want.smaller_count, out_result.smaller_count);
						mismatches++;
					end
					if (out_result.end_of_row !== want.end_of_row) begin
						$display("%0t: end_of_row expected %0b, actual %0b", $time,
							want.end_of_row, out_result.end_of_row);
						mismatches++;
					end
					if (out_result.end_of_frame !== want.end_of_frame) begin
						$display("%0t: end_of_frame expected %0b, actual %0b", $time,
							want.end_of_frame, out_result.end_of_frame);
						mismatches++;
					end
				end
			end
			item_taken = item_valid && !item_stall;
			if (item_taken) predict_counts(in_item);
		end
	end

	// Watchdog: any transfer on any channel counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d clocks, %0d results still expected", $time,
				quiet_cycles, expected_counts.size());
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int         rows;
		int         cols;
		int         m;
		int         n;
		int         frames;
		int         f;
		int         k;
		int         pix;
		int         cut;
		int         random_items;
		value_mix_t mix;
		random_items = 0;
		for (k = 0; k < LINE_DEPTH; k++) begin
			upper_line[k]  = '0;
			middle_line[k] = '0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// After reset the frame is one row of one column, so every pixel is a whole
		// frame and its result comes out only on a drain tick. The first drain
		// finds nothing yet, the third finds the frame already drained, and the
		// last two pixels show a new frame replacing one that was never drained.
		queue_drains(1);
		queue_pixel_value(PIX_MAX);
		queue_drains(2);
		queue_pixel_value(PIX_MIN);
		queue_pixel_value('0);
		wait_for_quiet();

		// Writes to the spare indexes must neither change the geometry nor restart
		// the frame: the pixel above is still waiting to be drained.
		write_reg(REG_SPARE_LO, CFG_DATA_BITS'($urandom));
		write_reg(REG_SPARE_HI, CFG_DATA_BITS'($urandom));
		queue_drains(2);
		wait_for_quiet();

		// Zero rows and zero columns both behave as one.
		write_reg(REG_FRAME_ROWS, '0);
		write_reg(REG_FRAME_COLS, '0);
		geometries++;
		queue_pixel_value(-1);
		queue_drains(1);
		wait_for_quiet();

		// A 3x3 frame whose center beats all eight neighbors, with the minimum, the
		// maximum and the values around zero placed to catch unsigned comparisons.
		write_reg(REG_FRAME_ROWS, 16'd3);
		write_reg(REG_FRAME_COLS, 16'd3);
		geometries++;
		queue_pixel_value(-1);
		queue_pixel_value(PIX_MIN);
		queue_pixel_value(1);
		queue_pixel_value(PIX_MIN);
		queue_pixel_value(PIX_MAX);
		queue_pixel_value('0);
		queue_pixel_value(1);
		queue_pixel_value(PIX_MIN);
		queue_pixel_value(-1);
		queue_drains(4);
		wait_for_quiet();

		// Widest frame: all data bits set means 2047 columns, clamped to the line
		// depth. A full first row writes every line entry and wraps at the top
		// column; a few pixels of the second row then show that the row really
		// ended there. Drains find the frame incomplete, and the next setting cuts it.
		write_reg(REG_FRAME_COLS, '1);
		write_reg(REG_FRAME_ROWS, 16'd2);
		geometries++;
		for (k = 0; k < LINE_DEPTH + 16; k++) queue_pixel(value_mix_t'($urandom_range(0, 2)));
		queue_drains(2);

		// Random part: small geometries, mostly whole frames followed by a full
		// drain, mixed with partial drains, missing drains, stray drain ticks
		// inside frames, frames cut short by a register write, and the tallest
		// frame, which never completes.
		while (random_items < RANDOM_ITEMS) begin
			wait_for_quiet();
			case ($urandom_range(0, 9))
				0:       rows = 0;
				1:       rows = 65535;
				2, 3:    rows = 1;
				default: rows = $urandom_range(2, 6);
			endcase
			case ($urandom_range(0, 9))
				0:       cols = 0;
				1:       cols = 1;
				2:       cols = 2;
				default: cols = $urandom_range(3, 12);
			endcase
			// The upper bits of a column write are outside the register and must be
			// dropped.
			if ($urandom_range(0, 1)) begin
				write_reg(REG_FRAME_ROWS, CFG_DATA_BITS'(rows));
				write_reg(REG_FRAME_COLS, {5'($urandom), FRAME_COLS_BITS'(cols)});
			end else begin
				write_reg(REG_FRAME_COLS, {5'($urandom), FRAME_COLS_BITS'(cols)});
				write_reg(REG_FRAME_ROWS, CFG_DATA_BITS'(rows));
			end
			if ($urandom_range(0, 3) == 0) begin
				write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
					CFG_DATA_BITS'($urandom));
			end
			geometries++;
			m   = rows_in_use();
			n   = cols_in_use();
			mix = value_mix_t'($urandom_range(0, 2));
			if (rows == 65535) begin
				pix = n * $urandom_range(2, 8) + $urandom_range(0, n - 1);
				for (k = 0; k < pix; k++) begin
					if ($urandom_range(0, 24) == 0) queue_drains(1);
					queue_pixel(mix);
				end
				random_items += pix;
			end else begin
				frames = $urandom_range(1, 3);
				for (f = 0; f < frames; f++) begin
					pix = m * n;
					if (f == frames - 1 && $urandom_range(0, 4) == 0) pix = $urandom_range(1, pix);
					for (k = 0; k < pix; k++) begin
						if ($urandom_range(0, 24) == 0) queue_drains(1);
						queue_pixel(mix);
					end
					case ($urandom_range(0, 9))
						0:       cut = 0;
						1:       cut = $urandom_range(0, n - 1);
						default: cut = n + $urandom_range(0, 2);
					endcase
					queue_drains(cut);
					random_items += pix + ((cut < n) ? cut : n);
				end
			end
		end

		wait_for_quiet();
		$display("Ran %0d frame geometries with %0d pixels and %0d drain ticks.", geometries,
			pixels_queued, drains_queued);
		$display("Checked %0d neighbor counts, %0d mismatches, %0d left unseen.", results_checked,
			mismatches, expected_counts.size());
		if (mismatches == 0 && expected_counts.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
